// ===== src/btha_pkg.sv =====
// Shared types and constants for the boundary tag heap allocator.
// Field widths, result status codes and header word layout.
// No dependencies.
package btha_pkg;

    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned REQ_W    = 17;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned WORD_W   = 32;

    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned HOLE_POS = 24;
    localparam int unsigned LAST_POS = 25;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned PAGE_W     = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'h1FFFF;
    localparam logic [LEN_W-1:0]   LEN_RESET    = 17'h10000;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC = 2'd0,
        ST_FREED = 2'd1,
        ST_NOFIT = 2'd2
    } t_status;

endpackage

// ===== src/boundary_tag_heap_allocator_top.sv =====
// Boundary tag first-fit heap allocator: control sequencer and byte-banked heap memory.
// Depends on btha_pkg for field widths, status codes and header layout.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_stall    | opcode, request_size, block_address
//   out     | output    | o_out_valid / i_out_stall  | status, payload_address, bytes_in_use
//   cfg     | input     | psel penable pwrite pready | paddr, pwdata, prdata
//
// Allocate reads block headers until one fits, then writes its header on an exact fit
// or four words on a split; free marks the header as a hole and merges free neighbours.
// The next item can be taken in the cycle after the result register loads. The heap
// memory has one port per byte bank and allows one word access per cycle. Reset and
// every register write run a clearing pass over the heap, during which no item is taken.
// A result waits in the output register under stall while the next item is taken.
module boundary_tag_heap_allocator_top #(
    parameter int unsigned HEAP_BYTES   = 65536,
    parameter int unsigned HEADER_BYTES = 12,
    parameter int unsigned FOOTER_BYTES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [btha_pkg::REQ_W-1:0]         i_request_size,
    input  logic [btha_pkg::ADDR_W-1:0]        i_block_address,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [btha_pkg::STATUS_W-1:0]      o_status,
    output logic [btha_pkg::ADDR_W-1:0]        o_payload_address,
    output logic [btha_pkg::COUNT_W-1:0]       o_bytes_in_use,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import btha_pkg::*;

    localparam int unsigned OV   = HEADER_BYTES + FOOTER_BYTES;
    localparam int unsigned ROWS = (HEAP_BYTES + 3) / 4;
    localparam int unsigned RW   = $clog2(ROWS);
    localparam int unsigned AW   = $clog2(HEAP_BYTES);
    localparam int unsigned LW   = $clog2(HEAP_BYTES + 1);
    localparam int unsigned CW   = ((LW > SIZE_W) ? LW : SIZE_W) + 2;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_WRD, S_WCHK, S_AEX, S_AW1, S_AW2, S_AW3, S_AW4,
        S_FCHK, S_FRD, S_FW, S_JRCHK, S_JRRD, S_JRQ, S_JRW2,
        S_JLST, S_JLLH, S_JLRDL, S_JLLW, S_JLRDW, S_JLW1, S_JLW2, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_READ,
        MOP_WRITE
    } t_mop;

    t_state               r_state, n_state;
    logic [RW-1:0]        r_row, n_row;
    logic [ADDR_W-1:0]    r_heap_base, n_heap_base;
    logic [LEN_W-1:0]     r_heap_length, n_heap_length;
    logic [LW-1:0]        r_mlen, n_mlen;
    logic [COUNT_W-1:0]   r_used, n_used;
    logic [REQ_W-1:0]     r_req, n_req;
    logic [ADDR_W-1:0]    r_baddr, n_baddr;
    logic [CW-1:0]        r_block, n_block;
    logic [CW-1:0]        r_blockk, n_blockk;
    logic [PAGE_W-1:0]    r_pb12, n_pb12;
    logic [LW-1:0]        r_off, n_off;
    logic [SIZE_W-1:0]    r_sz, n_sz;
    logic [CW-1:0]        r_rem, n_rem;
    logic [WORD_W-1:0]    r_w, n_w;
    logic [LW-1:0]        r_r, n_r;
    logic [SIZE_W-1:0]    r_rsz, n_rsz;
    logic [LW-1:0]        r_lh, n_lh;
    logic [SIZE_W-1:0]    r_lsz, n_lsz;
    logic [SIZE_W-1:0]    r_tsz, n_tsz;
    t_status              r_res_status, n_res_status;
    logic [ADDR_W-1:0]    r_res_addr, n_res_addr;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ADDR_W-1:0]    r_out_addr, n_out_addr;
    logic [COUNT_W-1:0]   r_out_used, n_out_used;
    logic [1:0]           r_rd_lo;

    t_mop                 c_mop;
    logic [AW-1:0]        c_moff;
    logic [WORD_W-1:0]    c_mwdat;
    logic [WORD_W-1:0]    c_q;
    logic [WORD_W-1:0]    c_clr_word;
    logic [7:0]           r_bank_q [4];
    logic                 c_cfg_we;

    logic [SIZE_W-1:0]    c_sz;
    logic [CW-1:0]        c_rr;
    logic [CW-1:0]        c_nb;
    logic [PAGE_W-1:0]    c_a12;
    logic                 c_bad, c_fits;
    logic [ADDR_W-1:0]    c_foff;
    logic [SIZE_W-1:0]    c_payload;
    logic [COUNT_W:0]     c_sum;
    logic [CW-1:0]        c_blk_in;

    function automatic logic [LW-1:0] f_mlen(input logic [LEN_W-1:0] v);
        logic [LW-1:0] res;
        if (32'(v) < 32'(HEAP_BYTES)) res = LW'(v);
        else                          res = LW'(HEAP_BYTES);
        return res;
    endfunction

    assign pready   = 1'b1;
    assign c_cfg_we = psel & penable & pwrite;
    assign prdata   = paddr[2] ? 32'(r_heap_length) : r_heap_base;

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_payload_address = r_out_addr;
    assign o_bytes_in_use    = r_out_used;

    assign c_clr_word = ((r_row == '0) && (CW'(r_mlen) >= CW'(OV))) ?
                        {6'b0, 2'b11, SIZE_W'(r_mlen)} : '0;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c_q[8*k +: 8] = r_bank_q[r_rd_lo + 2'(k)];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]    r_mem [ROWS];
        logic [1:0]    lane;
        logic [AW:0]   sum;
        logic [RW-1:0] row;
        logic [7:0]    wbyte;
        logic          we;

        assign lane  = 2'(b) - c_moff[1:0];
        assign sum   = {1'b0, c_moff} + (AW+1)'(lane);
        assign row   = (r_state == S_CLR) ? r_row : sum[RW+1:2];
        assign wbyte = (r_state == S_CLR) ? c_clr_word[8*b +: 8] : c_mwdat[{lane, 3'b000} +: 8];
        assign we    = (r_state == S_CLR) || (c_mop == MOP_WRITE);

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[row] <= wbyte;
            end else if (c_mop == MOP_READ) begin
                r_bank_q[b] <= r_mem[row];
            end
        end
    end

    always_comb begin
        c_sz      = c_q[SIZE_W-1:0];
        c_a12     = r_pb12 + r_off[PAGE_W-1:0];
        c_nb      = r_blockk - CW'(c_a12);
        c_bad     = (CW'(c_sz) < CW'(OV)) || (CW'(r_off) + CW'(c_sz) > CW'(r_mlen));
        c_fits    = c_q[HOLE_POS] && (CW'(c_sz) >= r_block) &&
                    (!c_q[LAST_POS] || (CW'(c_sz) >= c_nb));
        c_rr      = CW'(r_off) + CW'(r_w[SIZE_W-1:0]);
        c_foff    = r_baddr - r_heap_base - ADDR_W'(HEADER_BYTES);
        c_payload = (CW'(c_sz) >= CW'(OV)) ? (c_sz - SIZE_W'(OV)) : '0;
        c_sum     = {1'b0, r_used} + {1'b0, r_req};
        c_blk_in  = CW'(i_request_size) + CW'(OV);
    end

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_heap_base   = r_heap_base;
        n_heap_length = r_heap_length;
        n_mlen        = r_mlen;
        n_used        = r_used;
        n_req         = r_req;
        n_baddr       = r_baddr;
        n_block       = r_block;
        n_blockk      = r_blockk;
        n_pb12        = r_pb12;
        n_off         = r_off;
        n_sz          = r_sz;
        n_rem         = r_rem;
        n_w           = r_w;
        n_r           = r_r;
        n_rsz         = r_rsz;
        n_lh          = r_lh;
        n_lsz         = r_lsz;
        n_tsz         = r_tsz;
        n_res_status  = r_res_status;
        n_res_addr    = r_res_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_addr    = r_out_addr;
        n_out_used    = r_out_used;
        c_mop         = MOP_NONE;
        c_moff        = AW'(r_off);
        c_mwdat       = '0;

        case (r_state)
            S_CLR: begin
                if (r_row == RW'(ROWS - 1)) n_state = S_IDLE;
                else                         n_row   = r_row + RW'(1);
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_request_size;
                    n_baddr      = i_block_address;
                    n_res_addr   = '0;
                    n_off        = '0;
                    n_block      = c_blk_in;
                    n_blockk     = c_blk_in + CW'(FOOTER_BYTES) + CW'(2 * PAGE_BYTES);
                    n_pb12       = r_heap_base[PAGE_W-1:0] + c_blk_in[PAGE_W-1:0];
                    if (i_opcode) begin
                        n_res_status = ST_FREED;
                        n_state      = S_FCHK;
                    end else begin
                        n_res_status = ST_NOFIT;
                        n_state      = S_WRD;
                    end
                end
            end
            S_WRD: begin
                if (CW'(r_off) + CW'(HEADER_BYTES) > CW'(r_mlen)) begin
                    n_state = S_DONE;
                end else begin
                    c_mop   = MOP_READ;
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                n_w   = c_q;
                n_sz  = c_sz;
                n_rem = CW'(c_sz) - r_block;
                if (c_bad) begin
                    n_state = S_DONE;
                end else if (c_fits && (CW'(c_sz) == r_block)) begin
                    n_state = S_AEX;
                end else if (c_fits && (CW'(c_sz) - r_block >= CW'(OV))) begin
                    n_state = S_AW1;
                end else if (c_q[LAST_POS]) begin
                    n_state = S_DONE;
                end else begin
                    n_off   = LW'(CW'(r_off) + CW'(c_sz));
                    n_state = S_WRD;
                end
                if (!c_bad && c_fits && ((CW'(c_sz) == r_block) ||
                                         (CW'(c_sz) - r_block >= CW'(OV)))) begin
                    n_res_status = ST_ALLOC;
                    n_res_addr   = r_heap_base + ADDR_W'(r_off) + ADDR_W'(HEADER_BYTES);
                    n_used       = c_sum[COUNT_W] ? COUNT_MAX : c_sum[COUNT_W-1:0];
                end
            end
            S_AEX: begin
                c_mop   = MOP_WRITE;
                c_mwdat = r_w & ~(WORD_W'(1) << HOLE_POS);
                n_state = S_DONE;
            end
            S_AW1: begin
                c_mop   = MOP_WRITE;
                c_moff  = AW'(CW'(r_off) + r_block);
                c_mwdat = {6'b0, r_w[LAST_POS], 1'b1, r_rem[SIZE_W-1:0]};
                n_state = S_AW2;
            end
            S_AW2: begin
                c_mop   = MOP_WRITE;
                c_moff  = AW'(CW'(r_off) + CW'(r_sz) - CW'(FOOTER_BYTES));
                c_mwdat = WORD_W'(CW'(r_off) + r_block);
                n_state = S_AW3;
            end
            S_AW3: begin
                c_mop   = MOP_WRITE;
                c_moff  = AW'(CW'(r_off) + r_block - CW'(FOOTER_BYTES));
                c_mwdat = WORD_W'(r_off);
                n_state = S_AW4;
            end
            S_AW4: begin
                c_mop   = MOP_WRITE;
                c_mwdat = {8'b0, r_block[SIZE_W-1:0]};
                n_state = S_DONE;
            end
            S_FCHK: begin
                if ({1'b0, c_foff} + 33'(OV) > 33'(r_mlen)) begin
                    n_state = S_DONE;
                end else begin
                    n_off   = LW'(c_foff);
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                c_mop   = MOP_READ;
                n_state = S_FW;
            end
            S_FW: begin
                c_mop   = MOP_WRITE;
                c_mwdat = c_q | (WORD_W'(1) << HOLE_POS);
                n_w     = c_q | (WORD_W'(1) << HOLE_POS);
                n_used  = (SIZE_W'(r_used) > c_payload) ?
                          COUNT_W'(SIZE_W'(r_used) - c_payload) : '0;
                n_state = S_JRCHK;
            end
            S_JRCHK: begin
                if (r_w[LAST_POS] || (c_rr + CW'(HEADER_BYTES) > CW'(r_mlen))) begin
                    n_state = S_JLST;
                end else begin
                    n_r     = LW'(c_rr);
                    n_state = S_JRRD;
                end
            end
            S_JRRD: begin
                c_mop   = MOP_READ;
                c_moff  = AW'(r_r);
                n_state = S_JRQ;
            end
            S_JRQ: begin
                if ((CW'(c_sz) < CW'(OV)) || (CW'(r_r) + CW'(c_sz) > CW'(r_mlen)) ||
                    !c_q[HOLE_POS]) begin
                    n_state = S_JLST;
                end else begin
                    c_mop   = MOP_WRITE;
                    c_mwdat = {6'b0, c_q[LAST_POS], 1'b1, r_w[SIZE_W-1:0] + c_sz};
                    n_rsz   = c_sz;
                    n_state = S_JRW2;
                end
            end
            S_JRW2: begin
                c_mop   = MOP_WRITE;
                c_moff  = AW'(CW'(r_r) + CW'(r_rsz) - CW'(FOOTER_BYTES));
                c_mwdat = WORD_W'(r_off);
                n_state = S_JLST;
            end
            S_JLST: begin
                if (CW'(r_off) < CW'(FOOTER_BYTES)) begin
                    n_state = S_DONE;
                end else begin
                    c_mop   = MOP_READ;
                    c_moff  = AW'(CW'(r_off) - CW'(FOOTER_BYTES));
                    n_state = S_JLLH;
                end
            end
            S_JLLH: begin
                if ((c_q >= WORD_W'(r_off)) || ({1'b0, c_q} + 33'(OV) > 33'(r_mlen))) begin
                    n_state = S_DONE;
                end else begin
                    n_lh    = LW'(c_q);
                    n_state = S_JLRDL;
                end
            end
            S_JLRDL: begin
                c_mop   = MOP_READ;
                c_moff  = AW'(r_lh);
                n_state = S_JLLW;
            end
            S_JLLW: begin
                if (!c_q[HOLE_POS]) begin
                    n_state = S_DONE;
                end else begin
                    n_lsz   = c_sz;
                    n_state = S_JLRDW;
                end
            end
            S_JLRDW: begin
                c_mop   = MOP_READ;
                n_state = S_JLW1;
            end
            S_JLW1: begin
                c_mop   = MOP_WRITE;
                c_moff  = AW'(r_lh);
                c_mwdat = {6'b0, c_q[LAST_POS], 1'b1, r_lsz + c_sz};
                n_tsz   = c_sz;
                n_state = S_JLW2;
            end
            S_JLW2: begin
                if ((CW'(r_tsz) >= CW'(FOOTER_BYTES)) &&
                    (CW'(r_off) + CW'(r_tsz) <= CW'(r_mlen))) begin
                    c_mop   = MOP_WRITE;
                    c_moff  = AW'(CW'(r_off) + CW'(r_tsz) - CW'(FOOTER_BYTES));
                    c_mwdat = WORD_W'(r_lh);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_out_used   = r_used;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
                n_row   = '0;
            end
        endcase

        if (c_cfg_we) begin
            if (paddr[2]) begin
                n_heap_length = pwdata[LEN_W-1:0];
                n_mlen        = f_mlen(pwdata[LEN_W-1:0]);
            end else begin
                n_heap_base = pwdata;
            end
            n_used  = '0;
            n_row   = '0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_row         <= '0;
            r_heap_base   <= '0;
            r_heap_length <= LEN_RESET;
            r_mlen        <= f_mlen(LEN_RESET);
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row         <= n_row;
            r_heap_base   <= n_heap_base;
            r_heap_length <= n_heap_length;
            r_mlen        <= n_mlen;
            r_used        <= n_used;
            r_out_valid   <= n_out_valid;
        end
        r_req        <= n_req;
        r_baddr      <= n_baddr;
        r_block      <= n_block;
        r_blockk     <= n_blockk;
        r_pb12       <= n_pb12;
        r_off        <= n_off;
        r_sz         <= n_sz;
        r_rem        <= n_rem;
        r_w          <= n_w;
        r_r          <= n_r;
        r_rsz        <= n_rsz;
        r_lh         <= n_lh;
        r_lsz        <= n_lsz;
        r_tsz        <= n_tsz;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_used   <= n_out_used;
        if (c_mop == MOP_READ) begin
            r_rd_lo <= c_moff[1:0];
        end
    end

endmodule

// ===== tb/sv/boundary_tag_heap_allocator_top_tb.sv =====
// Testbench for the boundary tag first-fit heap allocator: random and directed
// allocate/free items checked against an in-bench heap predictor via a scoreboard.
// Depends on btha_pkg and boundary_tag_heap_allocator_top.
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_top_tb;
    import btha_pkg::*;

    localparam bit    OP_ALLOC     = 1'b0;
    localparam bit    OP_FREE      = 1'b1;
    localparam int    HDR          = 12;
    localparam int    FTR          = 4;
    localparam int    OVH          = HDR + FTR;
    localparam int    MEM_BYTES    = 65536;
    localparam int    REG_BASE     = 0;
    localparam int    REG_LENGTH   = 1;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
    } t_heap_result;

    class heap_scoreboard;
        bit [7:0]           mem [MEM_BYTES];
        logic [31:0]        base;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] used;
        t_heap_result       pending_q[$];
        logic [31:0]        live_q[$];
        logic [31:0]        freed_q[$];
        int                 errors;

        function new();
            base   = 0;
            length = LEN_RESET;
            rebuild();
        endfunction

        function longint mlen();
            return (length < MEM_BYTES) ? longint'(length) : longint'(MEM_BYTES);
        endfunction

        function logic [31:0] rd32(longint off);
            if (off + 4 > MEM_BYTES) return 0;
            return {mem[off+3], mem[off+2], mem[off+1], mem[off]};
        endfunction

        function void wr32(longint off, logic [31:0] v);
            if (off + 4 > MEM_BYTES) return;
            {mem[off+3], mem[off+2], mem[off+1], mem[off]} = v;
        endfunction

        function void rebuild();
            longint len;
            len  = mlen();
            used = 0;
            live_q.delete();
            freed_q.delete();
            foreach (mem[i]) mem[i] = 0;
            if (len < OVH) return;
            wr32(0, (32'(len) & 32'hFFFFFF) | (32'd1 << HOLE_POS) | (32'd1 << LAST_POS));
            wr32(len - FTR, 0);
        endfunction

        function void configure(int idx, logic [31:0] val);
            if (idx == REG_BASE) base = val;
            else length = val[LEN_W-1:0];
            rebuild();
        endfunction

        function bit page_ok(longint off, longint blk, longint sz);
            logic [31:0] a;
            longint need;
            a    = base + 32'(off) + 32'(blk);
            need = PAGE_BYTES + (PAGE_BYTES - longint'(a[PAGE_W-1:0])) + FTR;
            return sz >= need + blk;
        endfunction

        function bit alloc(logic [REQ_W-1:0] req, output logic [31:0] addr);
            longint len, blk, off, lim, sz, rem;
            logic [31:0] w;
            bit last, hole;
            len  = mlen();
            blk  = longint'(req) + OVH;
            off  = 0;
            lim  = len / OVH + 1;
            addr = 0;
            for (longint i = 0; i < lim; i++) begin
                if (off + HDR > len) break;
                w  = rd32(off);
                sz = w & 32'hFFFFFF;
                if (sz < OVH || off + sz > len) break;
                last = w[LAST_POS];
                hole = w[HOLE_POS];
                if (!(last && !page_ok(off, blk, sz)) && hole && sz >= blk) begin
                    if (sz == blk) begin
                        w[HOLE_POS] = 1'b0;
                        wr32(off, w);
                        addr = base + 32'(off) + HDR;
                        return 1;
                    end
                    rem = sz - blk;
                    if (rem >= OVH) begin
                        wr32(off + blk, (32'(rem) & 32'hFFFFFF) | (32'd1 << HOLE_POS)
                             | (w & (32'd1 << LAST_POS)));
                        wr32(off + sz - FTR, 32'(off + blk));
                        wr32(off + blk - FTR, 32'(off));
                        wr32(off, 32'(blk) & 32'hFFFFFF);
                        addr = base + 32'(off) + HDR;
                        return 1;
                    end
                end
                if (last) break;
                off += sz;
            end
            return 0;
        endfunction

        function void coalesce_next(longint off, longint len);
            logic [31:0] w, rw;
            longint sz, r, rsz;
            w = rd32(off);
            if (w[LAST_POS]) return;
            sz = w & 32'hFFFFFF;
            r  = off + sz;
            if (r + HDR > len) return;
            rw  = rd32(r);
            rsz = rw & 32'hFFFFFF;
            if (rsz < OVH || r + rsz > len || !rw[HOLE_POS]) return;
            wr32(off, (32'(sz + rsz) & 32'hFFFFFF) | (32'd1 << HOLE_POS)
                 | (rw & (32'd1 << LAST_POS)));
            wr32(r + rsz - FTR, 32'(off));
        endfunction

        function void coalesce_prev(longint off, longint len);
            logic [31:0] w, lw;
            longint lh, tsz;
            if (off < FTR) return;
            lh = rd32(off - FTR);
            if (lh >= off || lh + OVH > len) return;
            lw = rd32(lh);
            if (!lw[HOLE_POS]) return;
            w   = rd32(off);
            tsz = w & 32'hFFFFFF;
            wr32(lh, (32'((lw & 32'hFFFFFF) + tsz) & 32'hFFFFFF) | (32'd1 << HOLE_POS)
                 | (w & (32'd1 << LAST_POS)));
            if (tsz >= FTR && off + tsz <= len) wr32(off + tsz - FTR, 32'(lh));
        endfunction

        function void release_block(logic [31:0] addr);
            longint len, off, sz, pay;
            logic [31:0] w, o32;
            len = mlen();
            o32 = addr - base - HDR;
            off = longint'(o32);
            if (off + OVH > len) return;
            w   = rd32(off);
            sz  = w & 32'hFFFFFF;
            pay = (sz >= OVH) ? sz - OVH : 0;
            used = (longint'(used) > pay) ? COUNT_W'(longint'(used) - pay) : '0;
            w[HOLE_POS] = 1'b1;
            wr32(off, w);
            coalesce_next(off, len);
            coalesce_prev(off, len);
        endfunction

        function void note_input(bit op, logic [REQ_W-1:0] req, logic [31:0] baddr);
            t_heap_result r;
            logic [31:0] a;
            longint s;
            if (op == OP_ALLOC) begin
                if (alloc(req, a)) begin
                    s = longint'(used) + longint'(req);
                    used = (s > COUNT_MAX) ? COUNT_MAX : COUNT_W'(s);
                    r.status = ST_ALLOC;
                    r.addr   = a;
                    live_q.push_back(a);
                end else begin
                    r.status = ST_NOFIT;
                    r.addr   = 0;
                end
            end else begin
                release_block(baddr);
                foreach (live_q[i]) if (live_q[i] == baddr) begin
                    live_q.delete(i);
                    break;
                end
                freed_q.push_back(baddr);
                if (freed_q.size() > 16) void'(freed_q.pop_front());
                r.status = ST_FREED;
                r.addr   = 0;
            end
            r.count = used;
            pending_q.push_back(r);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [31:0] pa,
                                   logic [COUNT_W-1:0] cnt);
            t_heap_result e;
            if (pending_q.size() == 0) begin
                fail($sformatf("unexpected result status=%0d addr=%h count=%0d", st, pa, cnt));
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status)
                fail($sformatf("status exp=%0d act=%0d", e.status, st));
            if (pa !== e.addr)
                fail($sformatf("payload_address exp=%h act=%h", e.addr, pa));
            if (cnt !== e.count)
                fail($sformatf("bytes_in_use exp=%0d act=%0d", e.count, cnt));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_opcode = 1'b0;
    logic [REQ_W-1:0]   i_request_size = '0;
    logic [ADDR_W-1:0]  i_block_address = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]  o_payload_address;
    logic [COUNT_W-1:0] o_bytes_in_use;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    heap_scoreboard sb = new();
    longint         cycles = 0;
    int             burst_left = 4;
    int             stall_mode = 0;
    int             sent = 0;

    boundary_tag_heap_allocator_top u_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_payload_address, o_bytes_in_use);
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= (cycles[3:1] == 3'b000);
        endcase
    end

    task automatic send_item(bit op, logic [REQ_W-1:0] req, logic [31:0] baddr);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_request_size  <= req;
        i_block_address <= baddr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, req, baddr);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        drain();
        repeat (40) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.configure(idx, val);
    endtask

    task automatic random_items(int n);
        logic [31:0] a;
        int k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) == 0) drain();
            if ($urandom_range(0, 99) < 55) begin
                k = $urandom_range(0, 99);
                if (k < 80) send_item(OP_ALLOC, REQ_W'($urandom_range(0, 3000)), $urandom);
                else if (k < 95) send_item(OP_ALLOC, REQ_W'($urandom_range(0, 64)), $urandom);
                else send_item(OP_ALLOC, REQ_W'($urandom_range(0, 17'h1FFFF)), $urandom);
            end else begin
                k = $urandom_range(0, 99);
                if (k < 70 && sb.live_q.size() != 0)
                    a = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
                else if (k < 80 && sb.freed_q.size() != 0)
                    a = sb.freed_q[$urandom_range(0, sb.freed_q.size() - 1)];
                else if (k < 90)
                    a = sb.base + $urandom_range(0, 70000);
                else
                    a = $urandom;
                send_item(OP_FREE, REQ_W'($urandom), a);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_ALLOC, 17'd0, 32'h0);
        send_item(OP_ALLOC, 17'h10000, 32'h0);
        send_item(OP_ALLOC, 17'h1FFFF, 32'hFFFFFFFF);
        send_item(OP_ALLOC, 17'd100, 32'h0);
        send_item(OP_ALLOC, 17'd100, 32'h0);
        send_item(OP_ALLOC, 17'd100, 32'h0);
        send_item(OP_FREE, 17'd0, 32'd28);
        send_item(OP_ALLOC, 17'd90, 32'h0);
        send_item(OP_ALLOC, 17'd100, 32'h0);
        send_item(OP_FREE, 17'd0, 32'd28);
        send_item(OP_FREE, 17'd0, 32'd28);
        send_item(OP_FREE, 17'd0, 32'd144);
        send_item(OP_FREE, 17'd0, 32'hFFFFFFFF);
        send_item(OP_FREE, 17'h1FFFF, 32'h0);
        send_item(OP_ALLOC, 17'd40000, 32'h0);
        send_item(OP_ALLOC, 17'd30000, 32'h0);
        send_item(OP_FREE, 17'd0, 32'd12);
        drain();
        random_items(450);

        write_reg(REG_BASE, 32'hFFFFF000);
        write_reg(REG_LENGTH, 32'h1FFFF);
        random_items(400);

        write_reg(REG_BASE, 32'h00000ABC);
        write_reg(REG_LENGTH, 32'd8192);
        random_items(300);

        write_reg(REG_BASE, 32'hFFFFFFFF);
        write_reg(REG_LENGTH, 32'd0);
        random_items(40);

        write_reg(REG_LENGTH, 32'd15);
        random_items(40);

        write_reg(REG_LENGTH, 32'd16);
        send_item(OP_ALLOC, 17'd0, 32'h0);
        send_item(OP_FREE, 17'd0, 32'hFFFFFFFF + 32'd12);
        random_items(40);

        write_reg(REG_BASE, 32'h0);
        write_reg(REG_LENGTH, 32'h10000);
        random_items(600);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/btha_pkg.sv
src/boundary_tag_heap_allocator_top.sv
tb/sv/boundary_tag_heap_allocator_top_tb.sv
